// File: rtl/mstb_pkg.sv
// package for the maximum spanning tree bottleneck block: constants and codes
package mstb_pkg;
  localparam int unsigned MaxVertices = 32;
  localparam int unsigned MaxEdges = 256;
  localparam int unsigned WeightBits = 16;
  localparam int unsigned VidBits = 6;
  localparam int unsigned CfgIdxBits = 2;
  localparam logic [15:0] NoEdgeReset = 16'd1000;

  typedef enum logic [1:0] {
    OpClear = 2'd0,
    OpAdd   = 2'd1,
    OpRun   = 2'd2,
    OpNone  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CfgVertexCount = 2'd0,
    CfgStartVertex = 2'd1,
    CfgNoEdge      = 2'd2,
    CfgUnused      = 2'd3
  } cfg_idx_e;
endpackage

// File: rtl/max_spanning_tree_bottleneck.sv
// top level of the maximum spanning tree bottleneck block
// channel | direction | handshake                 | payload
// command | in        | start_i && !busy_o        | opcode, end_a, end_b, weight
// config  | in        | cfg_valid_i && cfg_ready_o| cfg_index_i, cfg_data_i
// result  | out       | result_valid_o            | vertex .. last
// run: per round the scan reads one stored edge a cycle from the edge memory, through one
// register stage, then a join step; up to n-1 rounds, then a min scan over the n vertices
// for the bottleneck, then one result per vertex
// reset clears control, counters and valid bits of the vertex table at once
// the receiver cannot stall: one result leaves every emit cycle
module max_spanning_tree_bottleneck #(
  parameter int unsigned MAX_VERTICES = mstb_pkg::MaxVertices,
  parameter int unsigned MAX_EDGES = mstb_pkg::MaxEdges,
  parameter int unsigned WEIGHT_BITS = mstb_pkg::WeightBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [1:0]            opcode_i,
  input  logic [5:0]            end_a_i,
  input  logic [5:0]            end_b_i,
  input  logic [15:0]           weight_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [mstb_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  output logic                  result_valid_o,
  output logic [5:0]            vertex_o,
  output logic [5:0]            parent_o,
  output logic [15:0]           entry_weight_o,
  output logic                  reached_o,
  output logic [15:0]           bottleneck_o,
  output logic                  overflow_o,
  output logic                  last_o
);
  import mstb_pkg::*;

  localparam int unsigned EBits = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CBits = $clog2(MAX_EDGES + 1);
  localparam int unsigned VBits = $clog2(MAX_VERTICES + 1);
  localparam int unsigned TBits = $clog2(MAX_VERTICES);
  localparam logic [WEIGHT_BITS-1:0] WMask = '1;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StScan = 6'b000010,
    StLast = 6'b000100,
    StJoin = 6'b001000,
    StMin  = 6'b010000,
    StEmit = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [5:0]  vcount_q, vstart_q;
  logic [15:0] noedge_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= 6'd32;
      vstart_q <= 6'd1;
      noedge_q <= NoEdgeReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgVertexCount: vcount_q <= cfg_data_i[5:0];
        CfgStartVertex: vstart_q <= cfg_data_i[5:0];
        CfgNoEdge:      noedge_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // saturated vertex count
  logic [VBits-1:0] n_w;
  always_comb begin
    if (vcount_q == 6'd0) n_w = VBits'(1);
    else if (32'(vcount_q) > MAX_VERTICES) n_w = VBits'(MAX_VERTICES);
    else n_w = VBits'(vcount_q);
  end

  logic accept;
  assign busy_o = (state_q != StIdle);
  assign accept = start_i && !busy_o;

  // edge memory
  logic [VBits-1:0]       mem_a [MAX_EDGES];
  logic [VBits-1:0]       mem_b [MAX_EDGES];
  logic [WEIGHT_BITS-1:0] mem_w [MAX_EDGES];
  logic [CBits-1:0] ecount_q;
  logic             dropped_q;
  logic [EBits-1:0] rd_addr;
  logic [VBits-1:0] rd_a_q, rd_b_q;
  logic [WEIGHT_BITS-1:0] rd_w_q;
  logic in_range_a, in_range_b;
  logic do_add;
  assign in_range_a = (32'(end_a_i) <= MAX_VERTICES);
  assign in_range_b = (32'(end_b_i) <= MAX_VERTICES);
  assign do_add = accept && (opcode_e'(opcode_i) == OpAdd) && (32'(ecount_q) < MAX_EDGES);

  always_ff @(posedge clk_i) begin
    if (do_add) begin
      // out-of-range endpoints map to 0, which a run ignores
      mem_a[ecount_q[EBits-1:0]] <= in_range_a ? VBits'(end_a_i) : '0;
      mem_b[ecount_q[EBits-1:0]] <= in_range_b ? VBits'(end_b_i) : '0;
      mem_w[ecount_q[EBits-1:0]] <= WEIGHT_BITS'(weight_i) & WMask;
    end
    rd_a_q <= mem_a[rd_addr];
    rd_b_q <= mem_b[rd_addr];
    rd_w_q <= mem_w[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecount_q  <= '0;
      dropped_q <= 1'b0;
    end else if (accept && opcode_e'(opcode_i) == OpClear) begin
      ecount_q  <= '0;
      dropped_q <= 1'b0;
    end else if (do_add) begin
      ecount_q <= ecount_q + CBits'(1);
    end else if (accept && opcode_e'(opcode_i) == OpAdd) begin
      dropped_q <= 1'b1;
    end
  end

  // vertex table: visited bits in flops, parent and weight as registers
  logic [MAX_VERTICES-1:0] vis_q;
  logic [VBits-1:0]        par_q [MAX_VERTICES];
  logic [WEIGHT_BITS-1:0]  jw_q  [MAX_VERTICES];

  // sequencer counters
  logic [CBits-1:0] eidx_q;
  logic [VBits-1:0] round_q, vidx_q;
  logic             have_q, rd_ok_q, any_q;
  logic [WEIGHT_BITS-1:0] bw_q, bott_q;
  logic [VBits-1:0] bc_q, bp_q;

  assign rd_addr = eidx_q[EBits-1:0];

  // classify the registered edge
  logic a_ok, b_ok, va, vb, cand;
  logic [VBits-1:0] cc, cp;
  always_comb begin
    a_ok = (rd_a_q != '0) && (rd_a_q <= n_w);
    b_ok = (rd_b_q != '0) && (rd_b_q <= n_w);
    va = a_ok ? vis_q[TBits'(rd_a_q - VBits'(1))] : 1'b0;
    vb = b_ok ? vis_q[TBits'(rd_b_q - VBits'(1))] : 1'b0;
    cand = rd_ok_q && a_ok && b_ok && (va != vb);
    cc = va ? rd_b_q : rd_a_q;
    cp = va ? rd_a_q : rd_b_q;
  end

  logic better;
  mstb_cand_cmp #(.WeightBits(WEIGHT_BITS), .VBits(VBits)) u_cmp (
    .have_best_i(have_q), .best_w_i(bw_q), .best_c_i(bc_q), .best_p_i(bp_q),
    .w_i(rd_w_q), .c_i(cc), .p_i(cp), .better_o(better)
  );

  logic [TBits-1:0] vt;
  assign vt = TBits'(vidx_q - VBits'(1));
  logic start_ok;
  assign start_ok = (vstart_q != 6'd0) && (32'(vstart_q) <= 32'(n_w));

  // min scan hit: a joined non-root vertex with a lighter non-zero entry weight
  logic min_hit;
  assign min_hit = vis_q[vt] && (vidx_q != VBits'(vstart_q)) && (jw_q[vt] != '0) &&
                   (!any_q || jw_q[vt] < bott_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept && opcode_e'(opcode_i) == OpRun) begin
        state_d = (start_ok && n_w > VBits'(1)) ? StScan : StMin;
      end
      StScan: if (eidx_q >= ecount_q) state_d = StLast;
      StLast: state_d = StJoin;
      StJoin: state_d = (!have_q || round_q + VBits'(1) >= n_w) ? StMin : StScan;
      StMin:  if (vidx_q == n_w) state_d = StEmit;
      StEmit: if (vidx_q == n_w) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      vis_q   <= '0;
      eidx_q  <= '0;
      round_q <= '0;
      vidx_q  <= '0;
      have_q  <= 1'b0;
      rd_ok_q <= 1'b0;
      any_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_ok_q <= (state_q == StScan) && (eidx_q < ecount_q);
      unique case (state_q)
        StIdle: begin
          if (accept && opcode_e'(opcode_i) == OpClear) begin
            vis_q <= '0;
          end
          if (accept && opcode_e'(opcode_i) == OpRun) begin
            vis_q   <= start_ok ? (MAX_VERTICES'(1) << TBits'(vstart_q - 6'd1)) : '0;
            eidx_q  <= '0;
            round_q <= VBits'(1);
            have_q  <= 1'b0;
            vidx_q  <= VBits'(1);
            any_q   <= 1'b0;
          end
        end
        StScan, StLast: begin
          if (eidx_q < ecount_q) eidx_q <= eidx_q + CBits'(1);
          if (cand && better) have_q <= 1'b1;
        end
        StJoin: begin
          if (have_q) vis_q[TBits'(bc_q - VBits'(1))] <= 1'b1;
          round_q <= round_q + VBits'(1);
          eidx_q  <= '0;
          have_q  <= 1'b0;
        end
        StMin: begin
          if (min_hit) any_q <= 1'b1;
          vidx_q <= (vidx_q == n_w) ? VBits'(1) : vidx_q + VBits'(1);
        end
        StEmit: vidx_q <= vidx_q + VBits'(1);
        default: ;
      endcase
    end
  end

  // payload registers: best candidate, tree table, bottleneck
  always_ff @(posedge clk_i) begin
    if ((state_q == StScan || state_q == StLast) && cand && better) begin
      bw_q <= rd_w_q;
      bc_q <= cc;
      bp_q <= cp;
    end
    if (state_q == StJoin && have_q) begin
      par_q[TBits'(bc_q - VBits'(1))] <= bp_q;
      jw_q[TBits'(bc_q - VBits'(1))]  <= bw_q;
    end
    if (state_q == StMin && min_hit)
      bott_q <= jw_q[vt];
  end

  // result ports
  logic vis_v;
  assign vis_v = vis_q[vt];
  assign result_valid_o = (state_q == StEmit);
  assign vertex_o       = 6'(vidx_q);
  assign reached_o      = vis_v;
  assign parent_o       = (vis_v && (vidx_q != VBits'(vstart_q))) ? 6'(par_q[vt]) : 6'd0;
  assign entry_weight_o = (vis_v && (vidx_q != VBits'(vstart_q))) ? 16'(jw_q[vt]) : 16'd0;
  assign bottleneck_o   = any_q ? 16'(bott_q) : noedge_q;
  assign overflow_o     = dropped_q;
  assign last_o         = (vidx_q == n_w);

  // checks
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !result_valid_o) else $error("emit past last");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o) else $error("result while idle");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ecount_q) <= MAX_EDGES) else $error("edge count overflow");
endmodule

// File: rtl/mstb_cand_cmp.sv
// candidate compare unit: decides whether a scanned edge beats the current best
module mstb_cand_cmp #(
  parameter int unsigned WeightBits = 16,
  parameter int unsigned VBits = 6
) (
  input  logic                  have_best_i,
  input  logic [WeightBits-1:0] best_w_i,
  input  logic [VBits-1:0]      best_c_i,
  input  logic [VBits-1:0]      best_p_i,
  input  logic [WeightBits-1:0] w_i,
  input  logic [VBits-1:0]      c_i,
  input  logic [VBits-1:0]      p_i,
  output logic                  better_o
);
  // heavier wins, then smaller child, then smaller parent
  assign better_o = !have_best_i || (w_i > best_w_i) ||
                    ((w_i == best_w_i) && ((c_i < best_c_i) ||
                     ((c_i == best_c_i) && (p_i < best_p_i))));
endmodule
